@@ design/door_actuator_fault_lockout_top_macros.svh @@
// assertion macros shared by the door actuator checker
`ifndef DOOR_ACTUATOR_FAULT_LOCKOUT_TOP_MACROS_SVH
`define DOOR_ACTUATOR_FAULT_LOCKOUT_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define DAFL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define DAFL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dafl_pkg.sv @@
// shared types, codes and helpers of the door actuator
`timescale 1ns / 1ps
package dafl_pkg;

  localparam int DAFL_DOORS = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_MOVE_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_CLOSE_OVERRUN = 3'd1;
  localparam logic [2:0] CFG_OPEN_SENSOR   = 3'd2;
  localparam logic [2:0] CFG_CLOSED_SENSOR = 3'd3;
  localparam logic [2:0] CFG_MAX_ERRORS    = 3'd4;

  localparam logic [15:0] RST_MOVE_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_CLOSE_OVERRUN = 16'd100;
  localparam logic [3:0]  RST_SENSOR        = 4'hF;
  localparam logic [2:0]  RST_MAX_ERRORS    = 3'd3;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_UP     = 3'd3,
    KIND_DOWN   = 3'd4,
    KIND_STOP   = 3'd5,
    KIND_RESET  = 3'd6,
    KIND_SPARE  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    OUT_ACCEPTED  = 3'd0,
    OUT_AT_LIMIT  = 3'd1,
    OUT_BAD_INDEX = 3'd2,
    OUT_DISABLED  = 3'd3,
    OUT_BUSY      = 3'd4,
    OUT_FINISHED  = 3'd5,
    OUT_IDLE_TICK = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    ST_UNKNOWN  = 3'd0,
    ST_OPEN     = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_MOVING   = 3'd3,
    ST_STOPPED  = 3'd4,
    ST_ERROR    = 3'd5,
    ST_DISABLED = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] move_timeout_ticks;
    logic [15:0] close_overrun_ticks;
    logic [3:0]  open_sensor_present;
    logic [3:0]  closed_sensor_present;
    logic [2:0]  max_errors;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] door;
    logic [3:0] open_limits;
    logic [3:0] closed_limits;
  } item_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [3:0] door_reported;
    status_t    door_state;
    logic [2:0] fault_count;
    logic [3:0] locked_mask;
    logic [3:0] drive_open_mask;
    logic [3:0] drive_close_mask;
  } res_t;

  // bit of a four-door mask, zero for doors beyond the mask
  function automatic logic mask_bit(input logic [3:0] v, input logic [3:0] d);
    return (d[3:2] == 2'b00) ? v[d[1:0]] : 1'b0;
  endfunction

endpackage

@@ design/dafl_cfg.sv @@
// configuration registers of the door actuator
`timescale 1ns / 1ps
module dafl_cfg
  import dafl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_timeout_ticks    <= RST_MOVE_TIMEOUT;
      cfg.close_overrun_ticks   <= RST_CLOSE_OVERRUN;
      cfg.open_sensor_present   <= RST_SENSOR;
      cfg.closed_sensor_present <= RST_SENSOR;
      cfg.max_errors            <= RST_MAX_ERRORS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MOVE_TIMEOUT:  cfg.move_timeout_ticks    <= cfg_data;
        CFG_CLOSE_OVERRUN: cfg.close_overrun_ticks   <= cfg_data;
        CFG_OPEN_SENSOR:   cfg.open_sensor_present   <= cfg_data[3:0];
        CFG_CLOSED_SENSOR: cfg.closed_sensor_present <= cfg_data[3:0];
        CFG_MAX_ERRORS:    cfg.max_errors            <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/dafl_in_stage.sv @@
// input register holding one command or tick beat
`timescale 1ns / 1ps
module dafl_in_stage
  import dafl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [3:0] door,
  input  logic [3:0] open_limits,
  input  logic [3:0] closed_limits,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.kind          <= kind_t'(kind);
      item.door          <= door;
      item.open_limits   <= open_limits;
      item.closed_limits <= closed_limits;
    end
  end

endmodule

@@ design/dafl_core.sv @@
// door table, timed move sequencer and per-beat step logic
`timescale 1ns / 1ps
module dafl_core
  import dafl_pkg::*;
#(
  parameter int DOORS = DAFL_DOORS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int DW    = (DOORS > 1) ? $clog2(DOORS) : 1;
  localparam int MASKN = (DOORS < 4) ? DOORS : 4;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_OPENING = 2'd1,
    PH_CLOSING = 2'd2,
    PH_OVERRUN = 2'd3
  } phase_t;

  status_t       door_status [DOORS];
  logic [2:0]    fail_count  [DOORS];
  logic          locked      [DOORS];
  logic          relay_open  [DOORS];
  logic          relay_close [DOORS];
  phase_t        phase;
  logic [DW-1:0] moving_door;
  logic [15:0]   move_timer;

  status_t       door_status_next [DOORS];
  logic [2:0]    fail_count_next  [DOORS];
  logic          locked_next      [DOORS];
  logic          relay_open_next  [DOORS];
  logic          relay_close_next [DOORS];
  phase_t        phase_next;
  logic [DW-1:0] moving_door_next;
  logic [15:0]   move_timer_next;

  logic          is_cmd;
  logic          cmd_path;
  logic          door_ok;
  logic [DW-1:0] sel;
  logic [3:0]    sel4;
  logic          os, cs, om, cm;
  logic [15:0]   tick_count;
  status_t       e_status;
  logic [2:0]    e_count;
  logic          e_locked, e_ro, e_rc;
  logic          we;
  logic          fin, fin_sensor, fin_made;
  status_t       fin_good;
  logic [2:0]    count_up;
  outcome_t      outcome;
  logic [3:0]    rep_door;
  logic          rep_valid;

  assign is_cmd   = (item.kind != KIND_TICK) && (item.kind != KIND_SPARE);
  assign door_ok  = ({1'b0, item.door} < 5'(DOORS));
  assign cmd_path = is_cmd && (phase == PH_IDLE) && door_ok;
  assign sel      = cmd_path ? item.door[DW-1:0] : moving_door;
  assign sel4     = 4'(sel);
  assign os       = mask_bit(cfg.open_sensor_present, sel4);
  assign cs       = mask_bit(cfg.closed_sensor_present, sel4);
  assign om       = mask_bit(item.open_limits, sel4);
  assign cm       = mask_bit(item.closed_limits, sel4);
  assign tick_count = move_timer + 16'd1;
  assign count_up = (fail_count[sel] == 3'd7) ? 3'd7 : fail_count[sel] + 3'd1;

  always_comb begin
    phase_next       = phase;
    moving_door_next = moving_door;
    move_timer_next  = move_timer;
    e_status   = door_status[sel];
    e_count    = fail_count[sel];
    e_locked   = locked[sel];
    e_ro       = relay_open[sel];
    e_rc       = relay_close[sel];
    we         = 1'b0;
    fin        = 1'b0;
    fin_sensor = 1'b0;
    fin_made   = 1'b0;
    fin_good   = ST_OPEN;
    outcome    = OUT_IDLE_TICK;
    rep_door   = 4'(moving_door);
    rep_valid  = 1'b1;

    case (item.kind)
      KIND_TICK: begin
        case (phase)
          PH_OPENING: begin
            fin_sensor = os;
            fin_made   = om;
            fin_good   = ST_OPEN;
            if (os && om) begin
              fin = 1'b1;
            end else if (tick_count < cfg.move_timeout_ticks) begin
              move_timer_next = tick_count;
            end else begin
              fin = 1'b1;
            end
          end
          PH_CLOSING: begin
            fin_sensor = cs;
            fin_made   = cm;
            fin_good   = ST_CLOSED;
            if (!(cs && cm) && (tick_count < cfg.move_timeout_ticks)) begin
              move_timer_next = tick_count;
            end else begin
              move_timer_next = '0;
              if (cfg.close_overrun_ticks != '0) begin
                phase_next = PH_OVERRUN;
              end else begin
                fin = 1'b1;
              end
            end
          end
          PH_OVERRUN: begin
            fin_sensor = cs;
            fin_made   = cm;
            fin_good   = ST_CLOSED;
            if (tick_count < cfg.close_overrun_ticks) begin
              move_timer_next = tick_count;
            end else begin
              fin = 1'b1;
            end
          end
          default: ;
        endcase
      end
      KIND_SPARE: ;
      default: begin
        if (phase != PH_IDLE) begin
          outcome = OUT_BUSY;
        end else if (!door_ok) begin
          outcome   = OUT_BAD_INDEX;
          rep_door  = item.door;
          rep_valid = 1'b0;
        end else begin
          rep_door = item.door;
          outcome  = OUT_ACCEPTED;
          if (locked[sel] && (item.kind inside {KIND_OPEN, KIND_CLOSE, KIND_UP, KIND_DOWN}))
          begin
            outcome = OUT_DISABLED;
          end else begin
            we = 1'b1;
            case (item.kind)
              KIND_OPEN: begin
                if (os && om) begin
                  e_status = ST_OPEN;
                  outcome  = OUT_AT_LIMIT;
                end else begin
                  e_ro             = 1'b1;
                  e_rc             = 1'b0;
                  phase_next       = PH_OPENING;
                  moving_door_next = sel;
                  move_timer_next  = '0;
                end
              end
              KIND_CLOSE: begin
                if (cs && cm) begin
                  e_status = ST_CLOSED;
                  outcome  = OUT_AT_LIMIT;
                end else begin
                  e_ro             = 1'b0;
                  e_rc             = 1'b1;
                  phase_next       = PH_CLOSING;
                  moving_door_next = sel;
                  move_timer_next  = '0;
                end
              end
              KIND_UP: begin
                e_ro     = 1'b1;
                e_rc     = 1'b0;
                e_status = ST_MOVING;
              end
              KIND_DOWN: begin
                e_ro     = 1'b0;
                e_rc     = 1'b1;
                e_status = ST_MOVING;
              end
              KIND_STOP: begin
                e_ro = 1'b0;
                e_rc = 1'b0;
                if (door_status[sel] == ST_MOVING) e_status = ST_STOPPED;
              end
              default: begin
                e_count  = '0;
                e_locked = 1'b0;
                if (cs && cm)      e_status = ST_CLOSED;
                else if (os && om) e_status = ST_OPEN;
                else               e_status = ST_STOPPED;
              end
            endcase
          end
        end
      end
    endcase

    // end of a timed move: relays off and the door judged on its limit switch
    if (fin) begin
      we              = 1'b1;
      outcome         = OUT_FINISHED;
      phase_next      = PH_IDLE;
      move_timer_next = '0;
      e_ro            = 1'b0;
      e_rc            = 1'b0;
      if (!fin_sensor) begin
        e_status = ST_UNKNOWN;
      end else if (fin_made) begin
        e_status = fin_good;
        e_count  = '0;
      end else begin
        e_count = count_up;
        if (count_up >= cfg.max_errors) begin
          e_locked = 1'b1;
          e_status = ST_DISABLED;
        end else begin
          e_status = ST_ERROR;
        end
      end
    end
  end

  always_comb begin
    door_status_next = door_status;
    fail_count_next  = fail_count;
    locked_next      = locked;
    relay_open_next  = relay_open;
    relay_close_next = relay_close;
    if (we) begin
      door_status_next[sel] = e_status;
      fail_count_next[sel]  = e_count;
      locked_next[sel]      = e_locked;
      relay_open_next[sel]  = e_ro;
      relay_close_next[sel] = e_rc;
    end
  end

  always_comb begin
    res.outcome          = outcome;
    res.door_reported    = rep_door;
    res.door_state       = rep_valid ? e_status : ST_UNKNOWN;
    res.fault_count      = rep_valid ? e_count : 3'd0;
    res.locked_mask      = '0;
    res.drive_open_mask  = '0;
    res.drive_close_mask = '0;
    for (int i = 0; i < MASKN; i++) begin
      res.locked_mask[i]      = locked_next[i];
      res.drive_open_mask[i]  = relay_open_next[i];
      res.drive_close_mask[i] = relay_close_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      moving_door <= '0;
      move_timer  <= '0;
      for (int i = 0; i < DOORS; i++) begin
        door_status[i] <= ST_UNKNOWN;
        fail_count[i]  <= '0;
        locked[i]      <= 1'b0;
        relay_open[i]  <= 1'b0;
        relay_close[i] <= 1'b0;
      end
    end else if (advance) begin
      phase       <= phase_next;
      moving_door <= moving_door_next;
      move_timer  <= move_timer_next;
      door_status <= door_status_next;
      fail_count  <= fail_count_next;
      locked      <= locked_next;
      relay_open  <= relay_open_next;
      relay_close <= relay_close_next;
    end
  end

endmodule

@@ design/dafl_out_stage.sv @@
// result register driving the output channel
`timescale 1ns / 1ps
module dafl_out_stage
  import dafl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       res,
  output logic       space,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] outcome,
  output logic [3:0] door_reported,
  output logic [2:0] door_state,
  output logic [2:0] fault_count,
  output logic [3:0] locked_mask,
  output logic [3:0] drive_open_mask,
  output logic [3:0] drive_close_mask
);

  res_t res_q;

  assign space = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res;
  end

  assign outcome          = res_q.outcome;
  assign door_reported    = res_q.door_reported;
  assign door_state       = res_q.door_state;
  assign fault_count      = res_q.fault_count;
  assign locked_mask      = res_q.locked_mask;
  assign drive_open_mask  = res_q.drive_open_mask;
  assign drive_close_mask = res_q.drive_close_mask;

endmodule

@@ design/door_actuator_fault_lockout_top.sv @@
// path: input register, then result register; the result is on the outputs in the cycle
// after its beat moves on from the input register and can be taken at the next edge
// throughput: one beat per cycle in each direction when neither channel stalls; the door
// table update, on the one addressed entry, and the move sequencer in dafl_core are loops
// reset: synchronous, active high; doors unknown, counts and locks cleared, relays off,
// no timed move, registers back to their defaults; usable as soon as reset is released
`timescale 1ns / 1ps
module door_actuator_fault_lockout_top
  import dafl_pkg::*;
#(
  parameter int DOORS = DAFL_DOORS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel: ticks and commands
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [3:0]  door,
  input  logic [3:0]  open_limits,
  input  logic [3:0]  closed_limits,
  // output channel: one result beat per input beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [3:0]  door_reported,
  output logic [2:0]  door_state,
  output logic [2:0]  fault_count,
  output logic [3:0]  locked_mask,
  output logic [3:0]  drive_open_mask,
  output logic [3:0]  drive_close_mask
);

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  item_valid;
  logic  space;
  logic  advance;

  // a held beat moves on whenever the result register is empty or draining
  assign advance = item_valid && space;

  dafl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dafl_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .door          (door),
    .open_limits   (open_limits),
    .closed_limits (closed_limits),
    .take          (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  // door table and move sequencer; state commits only when the beat moves on
  dafl_core #(
    .DOORS (DOORS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  dafl_out_stage u_out (
    .clk              (clk),
    .rst              (rst),
    .load             (advance),
    .res              (res),
    .space            (space),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .outcome          (outcome),
    .door_reported    (door_reported),
    .door_state       (door_state),
    .fault_count      (fault_count),
    .locked_mask      (locked_mask),
    .drive_open_mask  (drive_open_mask),
    .drive_close_mask (drive_close_mask)
  );

endmodule

@@ design/dafl_checker.sv @@
// port-level checker for the door actuator, bound to the top level
`timescale 1ns / 1ps
`include "door_actuator_fault_lockout_top_macros.svh"
module dafl_checker
  import dafl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] outcome,
  input logic [2:0] door_state,
  input logic [2:0] fault_count,
  input logic [3:0] drive_open_mask,
  input logic [3:0] drive_close_mask
);

  `DAFL_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(outcome) && $stable(door_state), "stalled result beat changed")
  `DAFL_ASSERT_NOW(a_relays_exclusive, clk, rst, out_valid, (drive_open_mask & drive_close_mask) == 4'd0, "open and close relays both on")
  `DAFL_ASSERT_NOW(a_bad_index_blank, clk, rst, out_valid && (outcome == OUT_BAD_INDEX), (door_state == ST_UNKNOWN) && (fault_count == 3'd0), "bad index beat carries door data")
  `DAFL_ASSERT_NOW(a_refused_locked, clk, rst, out_valid && (outcome == OUT_DISABLED), door_state == ST_DISABLED, "refused door is not in disabled state")

endmodule

bind door_actuator_fault_lockout_top dafl_checker u_dafl_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .outcome          (outcome),
  .door_state       (door_state),
  .fault_count      (fault_count),
  .drive_open_mask  (drive_open_mask),
  .drive_close_mask (drive_close_mask)
);
